[hdl/psrl_pkg.sv]
package psrl_pkg;

  localparam int RATE_ENTRIES_DEF  = 1024;
  localparam int BLOCK_ENTRIES_DEF = 256;

  localparam logic [23:0] RATE_LIMIT_RST  = 24'd5000;
  localparam logic [39:0] BLOCK_TIME_RST  = 40'd60000000000;
  localparam logic [39:0] WINDOW_RST      = 40'd1000000000;
  localparam logic [15:0] GUARD_PORT_RST  = 16'd51820;

  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] MIN_IPV4   = 16'd34;
  localparam logic [15:0] MIN_TCP    = 16'd54;
  localparam logic [15:0] MIN_UDP    = 16'd42;

  localparam logic [1:0] REG_RATE_LIMIT = 2'd0;
  localparam logic [1:0] REG_BLOCK_TIME = 2'd1;
  localparam logic [1:0] REG_WINDOW     = 2'd2;
  localparam logic [1:0] REG_GUARD_PORT = 2'd3;

  typedef enum logic [2:0] {
    RSN_SHORT      = 3'd0,
    RSN_OTHER      = 3'd1,
    RSN_RATE_OK    = 3'd2,
    RSN_OTHER_UDP  = 3'd3,
    RSN_RATE_DROP  = 3'd4,
    RSN_BLOCKED    = 3'd5,
    RSN_SHORT_TCP  = 3'd6,
    RSN_SHORT_UDP  = 3'd7
  } reason_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [63:0] start;
    logic [31:0] count;
  } rate_ent_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [63:0] expiry;
  } block_ent_t;

  function automatic logic [47:0] sat_inc48(input logic [47:0] v);
    return (v == '1) ? v : v + 48'd1;
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

[hdl/psrl_ram.sv]
module psrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/per_source_rate_limit_filter_unit.sv]
// channel   | ports                                                   | handshake
// ----------+---------------------------------------------------------+-------------------------
// packet in | frame_length now_ns ethertype ip_protocol src_ip dst_port| start & !busy
// result    | verdict reason metric_count                             | done, one cycle
// config    | psel penable pwrite paddr pwdata prdata pready          | apb, regs at 8*i
//
// a packet goes through accept with table read, lookup/compare, then decide with write-back.
// done strobes the cycle after decide; start is taken again in that same cycle,
// so a new packet is taken only once the last one is through, set by the table read-modify-write.
// after reset a clearing pass zeroes both tables; busy stays high during it.
// results cannot be stalled by the receiver.
module per_source_rate_limit_filter_unit #(
  parameter int RATE_ENTRIES  = psrl_pkg::RATE_ENTRIES_DEF,
  parameter int BLOCK_ENTRIES = psrl_pkg::BLOCK_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] frame_length,
  input  logic [63:0] now_ns,
  input  logic [15:0] ethertype,
  input  logic [7:0]  ip_protocol,
  input  logic [31:0] src_ip,
  input  logic [15:0] dst_port,
  output logic        done,
  output logic        verdict,
  output logic [2:0]  reason,
  output logic [47:0] metric_count
);
  import psrl_pkg::*;

  localparam int RATE_AW  = $clog2(RATE_ENTRIES);
  localparam int BLOCK_AW = $clog2(BLOCK_ENTRIES);
  localparam int CLR_AW   = (RATE_AW > BLOCK_AW) ? RATE_AW : BLOCK_AW;
  localparam int LAST_N   = (RATE_ENTRIES > BLOCK_ENTRIES) ? RATE_ENTRIES : BLOCK_ENTRIES;
  localparam logic [CLR_AW-1:0]   RATE_LAST  = CLR_AW'(RATE_ENTRIES - 1);
  localparam logic [CLR_AW-1:0]   BLOCK_LAST = CLR_AW'(BLOCK_ENTRIES - 1);
  localparam logic [CLR_AW-1:0]   CLR_LAST   = CLR_AW'(LAST_N - 1);
  localparam logic [RATE_AW-1:0]  RATE_MASK  = RATE_AW'(RATE_ENTRIES - 1);
  localparam logic [BLOCK_AW-1:0] BLOCK_MASK = BLOCK_AW'(BLOCK_ENTRIES - 1);

  // configuration
  logic [23:0] rate_limit;
  logic [39:0] block_time_ns;
  logic [39:0] window_ns;
  logic [15:0] guarded_udp_port;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit       <= RATE_LIMIT_RST;
      block_time_ns    <= BLOCK_TIME_RST;
      window_ns        <= WINDOW_RST;
      guarded_udp_port <= GUARD_PORT_RST;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_RATE_LIMIT: rate_limit       <= pwdata[23:0];
        REG_BLOCK_TIME: block_time_ns    <= pwdata[39:0];
        REG_WINDOW:     window_ns        <= pwdata[39:0];
        REG_GUARD_PORT: guarded_udp_port <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_RATE_LIMIT: prdata = {40'd0, rate_limit};
      REG_BLOCK_TIME: prdata = {24'd0, block_time_ns};
      REG_WINDOW:     prdata = {24'd0, window_ns};
      REG_GUARD_PORT: prdata = {48'd0, guarded_udp_port};
      default:        prdata = '0;
    endcase
  end

  // control
  state_t              state, state_next;
  logic [CLR_AW-1:0]   clr;
  logic                accept;

  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    case (state)
      ST_CLEAR: begin
        if (clr == CLR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (state == ST_CLEAR) begin
      clr <= clr + 1'b1;
    end
  end

  // captured packet
  logic [15:0]         in_len;
  logic [63:0]         in_now;
  logic [15:0]         in_etype;
  logic [7:0]          in_proto;
  logic [31:0]         in_ip;
  logic [15:0]         in_port;
  logic [RATE_AW-1:0]  rate_idx;
  logic [BLOCK_AW-1:0] block_idx;
  logic [15:0]         hash;
  logic [RATE_AW-1:0]  rate_ridx;
  logic [BLOCK_AW-1:0] block_ridx;

  assign hash       = src_ip[15:0] ^ src_ip[31:16];
  assign rate_ridx  = hash[RATE_AW-1:0] & RATE_MASK;
  assign block_ridx = hash[BLOCK_AW-1:0] & BLOCK_MASK;

  always_ff @(posedge clk) begin
    if (accept) begin
      in_len    <= frame_length;
      in_now    <= now_ns;
      in_etype  <= ethertype;
      in_proto  <= ip_protocol;
      in_ip     <= src_ip;
      in_port   <= dst_port;
      rate_idx  <= rate_ridx;
      block_idx <= block_ridx;
    end
  end

  // tables
  rate_ent_t           rate_rd, rate_wd;
  block_ent_t          block_rd, block_wd;
  logic                rate_we, block_we;
  logic [RATE_AW-1:0]  rate_wa;
  logic [BLOCK_AW-1:0] block_wa;

  psrl_ram #(
    .WIDTH ($bits(rate_ent_t)),
    .DEPTH (RATE_ENTRIES)
  ) u_rate_ram (
    .clk   (clk),
    .we    (rate_we),
    .waddr (rate_wa),
    .wdata (rate_wd),
    .re    (accept),
    .raddr (rate_ridx),
    .rdata (rate_rd)
  );

  psrl_ram #(
    .WIDTH ($bits(block_ent_t)),
    .DEPTH (BLOCK_ENTRIES)
  ) u_block_ram (
    .clk   (clk),
    .we    (block_we),
    .waddr (block_wa),
    .wdata (block_wd),
    .re    (accept),
    .raddr (block_ridx),
    .rdata (block_rd)
  );

  // lookup stage
  logic        early_q, blk_active_q, blk_expired_q;
  logic        tcp_q, udp_q, tcp_short_q, udp_short_q, port_match_q, rate_hit_q;
  logic [63:0] diff_q;
  logic [31:0] cnt_inc_q;
  logic        blk_hit;

  assign blk_hit = block_rd.valid && (block_rd.tag == in_ip);

  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP) begin
      early_q       <= (in_len < MIN_IPV4) || (in_etype != ETH_IPV4);
      blk_active_q  <= blk_hit && (in_now < block_rd.expiry);
      blk_expired_q <= blk_hit && !(in_now < block_rd.expiry);
      tcp_q         <= in_proto == PROTO_TCP;
      udp_q         <= in_proto == PROTO_UDP;
      tcp_short_q   <= in_len < MIN_TCP;
      udp_short_q   <= in_len < MIN_UDP;
      port_match_q  <= in_port == guarded_udp_port;
      rate_hit_q    <= rate_rd.valid && (rate_rd.tag == in_ip);
      diff_q        <= in_now - rate_rd.start;
      cnt_inc_q     <= sat_inc32(rate_rd.count);
    end
  end

  // decide stage
  logic        in_decide, new_window, over, do_rate, rate_drop;
  logic [47:0] passed_count, rate_drop_count, blocked_drop_count;
  logic        clr_rate_ok, clr_block_ok;

  assign in_decide  = (state == ST_DECIDE);
  assign new_window = !rate_hit_q || (diff_q > {24'd0, window_ns});
  assign over       = !new_window && (cnt_inc_q > {8'd0, rate_limit});
  assign do_rate    = !early_q && !blk_active_q &&
                      ((tcp_q && !tcp_short_q) || (udp_q && !udp_short_q && port_match_q));
  assign rate_drop  = do_rate && over;

  assign clr_rate_ok  = (clr <= RATE_LAST);
  assign clr_block_ok = (clr <= BLOCK_LAST);

  always_comb begin
    if (state == ST_CLEAR) begin
      rate_we  = clr_rate_ok;
      rate_wa  = clr[RATE_AW-1:0];
      rate_wd  = '0;
      block_we = clr_block_ok;
      block_wa = clr[BLOCK_AW-1:0];
      block_wd = '0;
    end else begin
      rate_we       = in_decide && do_rate;
      rate_wa       = rate_idx;
      rate_wd.valid = 1'b1;
      rate_wd.tag   = in_ip;
      rate_wd.start = new_window ? in_now : rate_rd.start;
      rate_wd.count = new_window ? 32'd1 : cnt_inc_q;
      // expired block entry is dropped unless the same packet re-blocks it
      block_we        = in_decide && (rate_drop || (!early_q && blk_expired_q));
      block_wa        = block_idx;
      block_wd.valid  = rate_drop;
      block_wd.tag    = in_ip;
      block_wd.expiry = in_now + {24'd0, block_time_ns};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      passed_count       <= '0;
      rate_drop_count    <= '0;
      blocked_drop_count <= '0;
      done               <= 1'b0;
    end else begin
      done <= in_decide;
      if (in_decide && !early_q) begin
        if (blk_active_q) begin
          blocked_drop_count <= sat_inc48(blocked_drop_count);
        end else if (rate_drop) begin
          rate_drop_count <= sat_inc48(rate_drop_count);
        end else if (!tcp_q && !udp_q) begin
          passed_count <= sat_inc48(passed_count);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_decide) begin
      verdict      <= 1'b0;
      metric_count <= '0;
      if (early_q) begin
        reason <= RSN_SHORT;
      end else if (blk_active_q) begin
        verdict      <= 1'b1;
        reason       <= RSN_BLOCKED;
        metric_count <= sat_inc48(blocked_drop_count);
      end else if (tcp_q && tcp_short_q) begin
        verdict <= 1'b1;
        reason  <= RSN_SHORT_TCP;
      end else if (udp_q && udp_short_q) begin
        reason <= RSN_SHORT_UDP;
      end else if (udp_q && !port_match_q) begin
        reason <= RSN_OTHER_UDP;
      end else if (tcp_q || udp_q) begin
        if (over) begin
          verdict      <= 1'b1;
          reason       <= RSN_RATE_DROP;
          metric_count <= sat_inc48(rate_drop_count);
        end else begin
          reason <= RSN_RATE_OK;
        end
      end else begin
        reason       <= RSN_OTHER;
        metric_count <= sat_inc48(passed_count);
      end
    end
  end

endmodule

[hdl/psrl_chk.sv]
module psrl_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        verdict,
  input logic [2:0]  reason,
  input logic [47:0] metric_count
);
  import psrl_pkg::*;

  logic accept;
  assign accept = start & ~busy;

  // every accepted packet gets its result
  a_latency: assert property (@(posedge clk) disable iff (rst) accept |-> ##3 done)
    else $error("missing result after accepted transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result without accepted transaction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("second transaction taken while one is in flight");

  a_verdict_reason: assert property (@(posedge clk) disable iff (rst)
    done |-> (verdict == ((reason == RSN_RATE_DROP) || (reason == RSN_BLOCKED) ||
                          (reason == RSN_SHORT_TCP))))
    else $error("verdict disagrees with reason");

  a_metric_zero: assert property (@(posedge clk) disable iff (rst)
    (done && ((reason == RSN_SHORT) || (reason == RSN_RATE_OK) ||
              (reason == RSN_OTHER_UDP) || (reason == RSN_SHORT_TCP) ||
              (reason == RSN_SHORT_UDP))) |-> (metric_count == 48'd0))
    else $error("metric count set for a reason without a counter");

endmodule

bind per_source_rate_limit_filter_unit psrl_chk u_psrl_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .verdict      (verdict),
  .reason       (reason),
  .metric_count (metric_count)
);
